[rtl/rsd_pkg.sv]
// Shared types and constants for the rectangle signed distance block.
// No dependencies; every other file of the block imports this package.
package rsd_pkg;

  // Coordinate and result width (signed fixed point, raw integer arithmetic)
  localparam int COORD_BITS = 32;

  // Edge differences carry one extra bit so they never wrap
  localparam int DIFF_W = COORD_BITS + 1;
  // Magnitudes of gaps and inside distances
  localparam int MAG_W  = COORD_BITS;
  localparam int PROD_W = 2 * MAG_W;
  // Square root chain: radicand, partial root and remainder widths
  localparam int ROOT_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int N_CELLS = ROOT_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_BITS;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RULE   = 3'd4;

  // Result saturation limits
  localparam logic [COORD_BITS-1:0] DIST_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] DIST_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [ROOT_W-1:0] ROOT_LIMIT =
    {{(ROOT_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};

  // Region of a point
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ZERO = 2'd0;  // on the boundary
  localparam kind_t KIND_OUT  = 2'd1;  // outside: Euclidean distance
  localparam kind_t KIND_NEG  = 2'd2;  // inside or open top edge: negative

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t left;
    coord_t right;
    coord_t bottom;
    coord_t top;
    logic   rule;
  } rect_cfg_t;

  // One slot of the square root chain plus the item's side payload
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [MAG_W-1:0]  mag;
    logic [SQ_W-1:0]   sq;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } cell_t;

endpackage

[rtl/rsd_ifs.sv]
// Handshake channel interfaces of the rectangle signed distance block.
// Depends on rsd_pkg for the payload types.
interface rsd_pt_if import rsd_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface rsd_res_if import rsd_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t distance;
  logic   saturated;

  modport source (output valid, distance, saturated, input ready);
  modport sink   (input valid, distance, saturated, output ready);
endinterface

interface rsd_cfg_if import rsd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/rsd_cfg_regs.sv]
// Configuration registers of the rectangle (edges and top edge rule).
// Depends on rsd_pkg and the rsd_cfg_if interface.
module rsd_cfg_regs import rsd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  rsd_cfg_if.sink          cfg_wr,
  output rect_cfg_t        rect
);

  rect_cfg_t rect_r;

  // Always take writes
  assign cfg_wr.ready = 1'b1;

  // Write the addressed register; drop indexes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_r.left   <= '0;
      rect_r.right  <= '0;
      rect_r.bottom <= '0;
      rect_r.top    <= '0;
      rect_r.rule   <= 1'b1;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_LEFT:   rect_r.left   <= coord_t'(cfg_wr.data);
        REG_RIGHT:  rect_r.right  <= coord_t'(cfg_wr.data);
        REG_BOTTOM: rect_r.bottom <= coord_t'(cfg_wr.data);
        REG_TOP:    rect_r.top    <= coord_t'(cfg_wr.data);
        REG_RULE:   rect_r.rule   <= cfg_wr.data[0];
        default: begin
        end
      endcase
    end
  end

  assign rect = rect_r;

endmodule

[rtl/rsd_front.sv]
// Front end: edge differences, region decision, squares and their sum.
// Four stages; feeds the head of the square root chain. Depends on rsd_pkg.
module rsd_front import rsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  coord_t    point_x,
  input  coord_t    point_y,
  input  rect_cfg_t rect,
  output cell_t     head
);

  // Stage A: signed differences to the left, right, bottom and top edges
  logic                     a_v_r;
  logic signed [DIFF_W-1:0] ax_r, bx_r, ay_r, by_r;
  logic                     a_rule_r;
  logic signed [DIFF_W-1:0] ax_nxt, bx_nxt, ay_nxt, by_nxt;

  assign ax_nxt = {point_x[COORD_BITS-1], point_x} - {rect.left[COORD_BITS-1], rect.left};
  assign bx_nxt = {rect.right[COORD_BITS-1], rect.right} - {point_x[COORD_BITS-1], point_x};
  assign ay_nxt = {point_y[COORD_BITS-1], point_y}
                  - {rect.bottom[COORD_BITS-1], rect.bottom};
  assign by_nxt = {rect.top[COORD_BITS-1], rect.top} - {point_y[COORD_BITS-1], point_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r    <= in_valid;
      ax_r     <= ax_nxt;
      bx_r     <= bx_nxt;
      ay_r     <= ay_nxt;
      by_r     <= by_nxt;
      a_rule_r <= rect.rule;
    end
  end

  // Stage B: classify the point, pick the gaps and the pairwise minima
  logic             b_v_r, b_in_r;
  kind_t            b_kind_r;
  logic [MAG_W-1:0] dx_r, dy_r, mx_r, my_r;
  logic             ax_neg, bx_neg, ay_neg, by_neg;
  logic             ax_pos, bx_pos, ay_pos, by_pos;
  logic             outside, strict_in, on_edge;
  logic [DIFF_W-1:0] ax_abs, bx_abs, ay_abs, by_abs;
  kind_t            kind_nxt;
  logic [MAG_W-1:0] dx_nxt, dy_nxt, mx_nxt, my_nxt;

  always_comb begin
    ax_neg  = ax_r[DIFF_W-1];
    bx_neg  = bx_r[DIFF_W-1];
    ay_neg  = ay_r[DIFF_W-1];
    by_neg  = by_r[DIFF_W-1];
    ax_pos  = !ax_neg && (ax_r != '0);
    bx_pos  = !bx_neg && (bx_r != '0);
    ay_pos  = !ay_neg && (ay_r != '0);
    by_pos  = !by_neg && (by_r != '0);
    outside   = ax_neg || bx_neg || ay_neg || by_neg;
    strict_in = ax_pos && bx_pos && ay_pos && by_pos;
    on_edge   = a_rule_r && (by_r == '0) && ax_pos && bx_pos;
    ax_abs  = -ax_r;
    bx_abs  = -bx_r;
    ay_abs  = -ay_r;
    by_abs  = -by_r;
    // Left gap wins over right gap when the rectangle is inverted
    if (ax_neg)      dx_nxt = ax_abs[MAG_W-1:0];
    else if (bx_neg) dx_nxt = bx_abs[MAG_W-1:0];
    else             dx_nxt = '0;
    if (ay_neg)      dy_nxt = ay_abs[MAG_W-1:0];
    else if (by_neg) dy_nxt = by_abs[MAG_W-1:0];
    else             dy_nxt = '0;
    mx_nxt = (ax_r < bx_r) ? ax_r[MAG_W-1:0] : bx_r[MAG_W-1:0];
    my_nxt = (ay_r < by_r) ? ay_r[MAG_W-1:0] : by_r[MAG_W-1:0];
    if (outside)                   kind_nxt = KIND_OUT;
    else if (strict_in || on_edge) kind_nxt = KIND_NEG;
    else                           kind_nxt = KIND_ZERO;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r    <= a_v_r;
      b_kind_r <= kind_nxt;
      b_in_r   <= strict_in;
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      mx_r     <= mx_nxt;
      my_r     <= my_nxt;
    end
  end

  // Stage C: square the gaps, settle the inside magnitude
  logic              c_v_r;
  kind_t             c_kind_r;
  logic [MAG_W-1:0]  c_mag_r;
  logic [PROD_W-1:0] dx2_r, dy2_r;
  logic [MAG_W-1:0]  mag_nxt;

  assign mag_nxt = (b_in_r && (my_r < mx_r)) ? my_r : mx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r    <= b_v_r;
      c_kind_r <= b_kind_r;
      c_mag_r  <= mag_nxt;
      dx2_r    <= PROD_W'(dx_r) * PROD_W'(dx_r);
      dy2_r    <= PROD_W'(dy_r) * PROD_W'(dy_r);
    end
  end

  // Stage D: sum of squares, start the root with an empty remainder
  cell_t head_r, head_nxt;

  always_comb begin
    head_nxt.valid = c_v_r;
    head_nxt.kind  = c_kind_r;
    head_nxt.mag   = c_mag_r;
    head_nxt.sq    = SQ_W'(dx2_r) + SQ_W'(dy2_r);
    head_nxt.rem   = '0;
    head_nxt.root  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.valid <= 1'b0;
    end else if (en) begin
      head_r <= head_nxt;
    end
  end

  assign head = head_r;

endmodule

[rtl/rsd_sqrt_cell.sv]
// One square root chain cell, settles one root bit per item. Uses rsd_pkg.
// Takes two radicand bits from its neighbor each cycle that en is high.
module rsd_sqrt_cell import rsd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  cell_t prev,
  output cell_t cur
);

  cell_t             cur_r, cur_nxt;
  logic [REM_W-1:0]  rem_sh, trial;
  logic [REM_W:0]    diff;
  logic              fits;

  // Bring down two radicand bits, try the next root bit
  always_comb begin
    rem_sh  = {prev.rem[REM_W-3:0], prev.sq[SQ_W-1 -: 2]};
    trial   = REM_W'({prev.root, 2'b01});
    diff    = {1'b0, rem_sh} - {1'b0, trial};
    fits    = !diff[REM_W];
    cur_nxt       = prev;
    cur_nxt.sq    = {prev.sq[SQ_W-3:0], 2'b00};
    cur_nxt.rem   = fits ? diff[REM_W-1:0] : rem_sh;
    cur_nxt.root  = {prev.root[ROOT_W-2:0], fits};
  end

  // Advance with the chain; hold on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.valid <= 1'b0;
    end else if (en) begin
      cur_r <= cur_nxt;
    end
  end

  assign cur = cur_r;

endmodule

[rtl/rsd_out_stage.sv]
// Output stage: forms the signed, saturated distance and holds it in a
// result register backed by a skid register. Depends on rsd_pkg, rsd_res_if.
module rsd_out_stage import rsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_t     last,
  rsd_res_if.source out_res,
  output logic      en
);

  logic   p_v_r, p_sat_r, sk_valid_r, sk_sat_r;
  coord_t p_dist_r, sk_dist_r;
  coord_t dist_nxt;
  logic   sat_nxt;
  logic   sk_valid_nxt;

  // The chain moves whenever the skid register is empty
  assign en = !sk_valid_r;

  // Form the result from the region and the root or inside magnitude
  always_comb begin
    dist_nxt = '0;
    sat_nxt  = 1'b0;
    case (last.kind)
      KIND_OUT: begin
        if (last.root > ROOT_LIMIT) begin
          dist_nxt = coord_t'(DIST_MAX);
          sat_nxt  = 1'b1;
        end else begin
          dist_nxt = coord_t'(last.root[COORD_BITS-1:0]);
        end
      end
      KIND_NEG: begin
        if (last.mag > MAG_W'(DIST_MIN)) begin
          dist_nxt = coord_t'(DIST_MIN);
          sat_nxt  = 1'b1;
        end else begin
          dist_nxt = coord_t'(~last.mag + 1'b1);
        end
      end
      default: begin
        dist_nxt = '0;
        sat_nxt  = 1'b0;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r    <= last.valid;
      p_dist_r <= dist_nxt;
      p_sat_r  <= sat_nxt;
    end
  end

  // Catch a refused item in the skid register, drop it once taken
  assign sk_valid_nxt = sk_valid_r ? !out_res.ready : (p_v_r && !out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_valid_r <= 1'b0;
    end else begin
      sk_valid_r <= sk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_valid_r) begin
      sk_dist_r <= p_dist_r;
      sk_sat_r  <= p_sat_r;
    end
  end

  // Oldest item first
  assign out_res.valid     = sk_valid_r || p_v_r;
  assign out_res.distance  = sk_valid_r ? sk_dist_r : p_dist_r;
  assign out_res.saturated = sk_valid_r ? sk_sat_r : p_sat_r;

endmodule

[rtl/rect_signed_distance.sv]
// Top level of the rectangle signed distance block.
// Depends on rsd_pkg, the channel interfaces, rsd_cfg_regs, rsd_front,
// rsd_sqrt_cell and rsd_out_stage.
//
// Takes one point per cycle while not stalled and returns one signed Q16.16
// distance per point, in order, after it has passed four front stages (edge
// differences, region decision, squaring, sum of squares), a chain of 33
// square root cells that each settle one root bit, and one result stage.
// A skid register behind the result stage absorbs a refused result; while it
// is full the chain holds and in_pt.ready is low, and it empties when the
// result is taken. Configuration writes are taken at any time and apply
// to points accepted after the write.
module rect_signed_distance import rsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rsd_pt_if.sink    in_pt,
  rsd_res_if.source out_res,
  rsd_cfg_if.sink   cfg_wr
);

  rect_cfg_t rect;
  logic      en;
  cell_t     chain [0:N_CELLS];

  rsd_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .rect   (rect)
  );

  // Accept a point whenever the chain moves
  assign in_pt.ready = en;

  rsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_pt.valid),
    .point_x  (in_pt.point_x),
    .point_y  (in_pt.point_y),
    .rect     (rect),
    .head     (chain[0])
  );

  // Square root chain, one root bit per cell
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    rsd_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .prev  (chain[i]),
      .cur   (chain[i+1])
    );
  end

  rsd_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .last    (chain[N_CELLS]),
    .out_res (out_res),
    .en      (en)
  );

endmodule

[rtl/rsd_checker.sv]
// Port-level checks for rect_signed_distance, attached by a bind below.
// Depends on rsd_pkg for the result limits.
module rsd_checker import rsd_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input coord_t distance,
  input logic   saturated
);

  // No result right after a reset cycle
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Input stalls only while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // A saturated result sits at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |->
      (distance == coord_t'(DIST_MAX)) || (distance == coord_t'(DIST_MIN)))
    else $error("saturated result not at a limit");

  // A refused result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(distance) && $stable(saturated))
    else $error("refused result changed");

endmodule

bind rect_signed_distance rsd_checker u_rsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_pt.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .distance  (out_res.distance),
  .saturated (out_res.saturated)
);
